/* rtl/ibs_pkg.sv */
// Package: shared types, constants and command codes for the indexed block search.
`timescale 1ns / 1ps

package ibs_pkg;

    localparam int DATA_DEPTH_DEF  = 256;
    localparam int INDEX_DEPTH_DEF = 64;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 8;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 9;

    localparam logic [CMD_W-1:0] CMD_WR_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_INDEX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [SLOT_W-1:0]       slot;
        logic signed [KEY_W-1:0] key;
        logic [SLOT_W-1:0]       first_pos;
        logic [SLOT_W-1:0]       last_pos;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_rsp;

    typedef struct packed {
        logic              data_we;
        logic              idx_we;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] first_pos;
        logic [SLOT_W-1:0] last_pos;
    } t_wr_req;

    typedef struct packed {
        logic              idx_rd;
        logic [CNT_W-1:0]  idx_addr;
        logic              data_rd;
        logic [SLOT_W-1:0] data_addr;
    } t_rd_req;

endpackage

/* rtl/ibs_store.sv */
// Key table and block index table memories with registered read ports.
`timescale 1ns / 1ps

module ibs_store #(
    parameter int DATA_DEPTH  = ibs_pkg::DATA_DEPTH_DEF,
    parameter int INDEX_DEPTH = ibs_pkg::INDEX_DEPTH_DEF,
    parameter int KEY_WIDTH   = ibs_pkg::KEY_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  ibs_pkg::t_wr_req                  i_wr,
    input  logic signed [KEY_WIDTH-1:0]       i_wr_key,
    input  ibs_pkg::t_rd_req                  i_rd,
    output logic signed [KEY_WIDTH-1:0]       o_data_key,
    output logic signed [KEY_WIDTH-1:0]       o_idx_key,
    output logic [ibs_pkg::SLOT_W-1:0]        o_idx_first,
    output logic [ibs_pkg::SLOT_W-1:0]        o_idx_last
);

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int DXW = (DAW > ibs_pkg::SLOT_W) ? DAW : ibs_pkg::SLOT_W;
    localparam int IXW = (IAW > ibs_pkg::SLOT_W) ? IAW : ibs_pkg::SLOT_W;

    logic signed [KEY_WIDTH-1:0]    data_mem [DATA_DEPTH];
    logic signed [KEY_WIDTH-1:0]    idx_key_mem [INDEX_DEPTH];
    logic [ibs_pkg::SLOT_W-1:0]     idx_first_mem [INDEX_DEPTH];
    logic [ibs_pkg::SLOT_W-1:0]     idx_last_mem [INDEX_DEPTH];

    logic [DXW-1:0] data_waddr_x;
    logic [DXW-1:0] data_raddr_x;
    logic [IXW-1:0] idx_waddr_x;
    logic [IXW-1:0] idx_raddr_x;

    assign data_waddr_x = DXW'(i_wr.slot);
    assign data_raddr_x = DXW'(i_rd.data_addr);
    assign idx_waddr_x  = IXW'(i_wr.slot);
    assign idx_raddr_x  = IXW'(i_rd.idx_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.data_we) begin
            data_mem[data_waddr_x[DAW-1:0]] <= i_wr_key;
        end
        if (i_rd.data_rd) begin
            o_data_key <= data_mem[data_raddr_x[DAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.idx_we) begin
            idx_key_mem[idx_waddr_x[IAW-1:0]]   <= i_wr_key;
            idx_first_mem[idx_waddr_x[IAW-1:0]] <= i_wr.first_pos;
            idx_last_mem[idx_waddr_x[IAW-1:0]]  <= i_wr.last_pos;
        end
        if (i_rd.idx_rd) begin
            o_idx_key   <= idx_key_mem[idx_raddr_x[IAW-1:0]];
            o_idx_first <= idx_first_mem[idx_raddr_x[IAW-1:0]];
            o_idx_last  <= idx_last_mem[idx_raddr_x[IAW-1:0]];
        end
    end

endmodule

/* rtl/ibs_ctrl.sv */
// Search sequencer: binary search over the index, then linear block scan, one compare a step.
`timescale 1ns / 1ps

module ibs_ctrl #(
    parameter int DATA_DEPTH = ibs_pkg::DATA_DEPTH_DEF,
    parameter int KEY_WIDTH  = ibs_pkg::KEY_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [KEY_WIDTH-1:0]       i_key,
    input  logic [ibs_pkg::CNT_W-1:0]         i_cnt,
    output logic                              o_busy,
    output ibs_pkg::t_rd_req                  o_rd,
    input  logic signed [KEY_WIDTH-1:0]       i_data_key,
    input  logic signed [KEY_WIDTH-1:0]       i_idx_key,
    input  logic [ibs_pkg::SLOT_W-1:0]        i_idx_first,
    input  logic [ibs_pkg::SLOT_W-1:0]        i_idx_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ibs_pkg::t_rsp                     o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_BLK_RD,
        S_BLK_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESULT
    } t_state;

    t_state                        r_state;
    logic signed [KEY_WIDTH-1:0]   r_key;
    logic [ibs_pkg::CNT_W-1:0]     r_lo;
    logic [ibs_pkg::CNT_W-1:0]     r_hi1;
    logic [ibs_pkg::POS_W-1:0]     r_i;
    logic [ibs_pkg::SLOT_W-1:0]    r_last;
    logic                          r_found;
    logic [ibs_pkg::POS_W-1:0]     r_pos;
    logic                          r_out_valid;
    ibs_pkg::t_rsp                 r_rsp;

    logic [ibs_pkg::CNT_W:0]       mid_sum;
    logic [ibs_pkg::CNT_W-1:0]     mid;
    logic [ibs_pkg::CNT_W-1:0]     n_lo;
    logic [ibs_pkg::CNT_W-1:0]     n_hi1;
    logic                          scan_ok;

    // mid = (lo + hi) / 2 with hi = hi1 - 1 and lo < hi1
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi1} - {{ibs_pkg::CNT_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[ibs_pkg::CNT_W:1];

    always_comb begin
        n_lo  = r_lo;
        n_hi1 = r_hi1;
        if (i_idx_key >= r_key) begin
            n_hi1 = mid;
        end else begin
            n_lo = mid + 1'b1;
        end
    end

    assign scan_ok = (r_i <= {1'b0, r_last}) && (32'(r_i) < DATA_DEPTH);

    always_comb begin
        o_rd = '0;
        unique case (r_state)
            S_PROBE_RD: begin
                o_rd.idx_rd   = 1'b1;
                o_rd.idx_addr = mid;
            end
            S_BLK_RD: begin
                o_rd.idx_rd   = r_hi1 < i_cnt;
                o_rd.idx_addr = r_hi1;
            end
            S_SCAN_RD: begin
                o_rd.data_rd   = scan_ok;
                o_rd.data_addr = r_i[ibs_pkg::SLOT_W-1:0];
            end
            default: begin
                o_rd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_RESULT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_key   <= i_key;
                        r_lo    <= '0;
                        r_hi1   <= i_cnt;
                        r_state <= S_PROBE_RD;
                    end
                end
                S_PROBE_RD: begin
                    r_state <= S_PROBE_CMP;
                end
                S_PROBE_CMP: begin
                    r_lo    <= n_lo;
                    r_hi1   <= n_hi1;
                    r_state <= (n_lo < n_hi1) ? S_PROBE_RD : S_BLK_RD;
                end
                S_BLK_RD: begin
                    if (r_hi1 < i_cnt) begin
                        r_state <= S_BLK_WAIT;
                    end else begin
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_state <= S_RESULT;
                    end
                end
                S_BLK_WAIT: begin
                    r_i     <= {1'b0, i_idx_first};
                    r_last  <= i_idx_last;
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (scan_ok) begin
                        r_state <= S_SCAN_CMP;
                    end else begin
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_state <= S_RESULT;
                    end
                end
                S_SCAN_CMP: begin
                    if (i_data_key == r_key) begin
                        r_found <= 1'b1;
                        r_pos   <= r_i + 1'b1;
                        r_state <= S_RESULT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_rsp.found    <= r_found;
                        r_rsp.position <= r_pos;
                        r_state        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

/* rtl/indexed_block_search.sv */
// Top level: request decode, block count register, key sizing, storage and sequencer.
`timescale 1ns / 1ps

// Indexed block search. Write requests (data key or index entry) are taken whenever
// no search runs. A search request runs under a sequencer, one compare per step:
// each binary-search probe of the index is a registered index read, then a
// compare, about ceil(log2(block_count + 1)) probes; then the block bounds are
// fetched (index read, then wait), and each data entry scanned is a registered
// data read, then a compare; the result then goes to the output register. The
// block stalls requests while a search runs; a finished result waits in the output
// register, and write requests are still taken while it waits. Memories have no
// reset; reading an entry never written returns undefined data.
module indexed_block_search #(
    parameter int DATA_DEPTH  = ibs_pkg::DATA_DEPTH_DEF,
    parameter int INDEX_DEPTH = ibs_pkg::INDEX_DEPTH_DEF,
    parameter int KEY_WIDTH   = ibs_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ibs_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  ibs_pkg::t_req               i_req,
    output logic                        o_valid,
    input  logic                        i_stall,
    output ibs_pkg::t_rsp               o_rsp
);

    logic [ibs_pkg::CNT_W-1:0]      r_block_count;
    logic [ibs_pkg::CNT_W-1:0]      cnt;
    logic                           busy;
    logic                           accept;
    logic signed [KEY_WIDTH-1:0]    key_sized;
    ibs_pkg::t_wr_req               wr;
    ibs_pkg::t_rd_req               rd;
    logic signed [KEY_WIDTH-1:0]    data_key;
    logic signed [KEY_WIDTH-1:0]    idx_key;
    logic [ibs_pkg::SLOT_W-1:0]     idx_first;
    logic [ibs_pkg::SLOT_W-1:0]     idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= ibs_pkg::CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            r_block_count <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_block_count == '0) begin
            cnt = ibs_pkg::CNT_W'(1);
        end else if (32'(r_block_count) > INDEX_DEPTH) begin
            cnt = ibs_pkg::CNT_W'(INDEX_DEPTH);
        end else begin
            cnt = r_block_count;
        end
    end

    generate
        if (KEY_WIDTH <= ibs_pkg::KEY_W) begin : g_key_trunc
            assign key_sized = i_req.key[KEY_WIDTH-1:0];
        end else begin : g_key_ext
            assign key_sized = {{(KEY_WIDTH - ibs_pkg::KEY_W){i_req.key[ibs_pkg::KEY_W-1]}},
                                i_req.key};
        end
    endgenerate

    assign accept = i_valid && !busy;

    always_comb begin
        wr.data_we   = accept && (i_req.cmd == ibs_pkg::CMD_WR_DATA)
                       && (32'(i_req.slot) < DATA_DEPTH);
        wr.idx_we    = accept && (i_req.cmd == ibs_pkg::CMD_WR_INDEX)
                       && (32'(i_req.slot) < INDEX_DEPTH);
        wr.slot      = i_req.slot;
        wr.first_pos = i_req.first_pos;
        wr.last_pos  = i_req.last_pos;
    end

    ibs_store #(
        .DATA_DEPTH (DATA_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr       (wr),
        .i_wr_key   (key_sized),
        .i_rd       (rd),
        .o_data_key (data_key),
        .o_idx_key  (idx_key),
        .o_idx_first(idx_first),
        .o_idx_last (idx_last)
    );

    ibs_ctrl #(
        .DATA_DEPTH(DATA_DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && (i_req.cmd == ibs_pkg::CMD_SEARCH)),
        .i_key      (key_sized),
        .i_cnt      (cnt),
        .o_busy     (busy),
        .o_rd       (rd),
        .i_data_key (data_key),
        .i_idx_key  (idx_key),
        .i_idx_first(idx_first),
        .i_idx_last (idx_last),
        .o_out_valid(o_valid),
        .i_out_stall(i_stall),
        .o_rsp      (o_rsp)
    );

    assign o_stall = busy;

endmodule

/* rtl/ibs_checker.sv */
// Port-level checks for the indexed block search, bound to the top level.
`timescale 1ns / 1ps

module ibs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input ibs_pkg::t_req             i_req,
    input logic                      o_valid,
    input logic                      i_stall,
    input ibs_pkg::t_rsp             o_rsp
);

    // held result stays put
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // position is nonzero exactly when found
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.found == (o_rsp.position != '0)))
        else $error("found and position disagree");

    // a search holds off further requests
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_req.cmd == ibs_pkg::CMD_SEARCH) |=> o_stall)
        else $error("search request did not make the block busy");

    // a new result only appears at the end of a search
    a_rsp_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a running search");

endmodule

bind indexed_block_search ibs_checker u_ibs_checker (.*);
